// ===== hw/rtl/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the golden-section search controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned FractionBits  = 16;
  localparam int unsigned CountWidth    = 10;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned ProdWidth     = ValueWidth + FractionBits;

  // 0.382 in Q0.16
  localparam logic [FractionBits-1:0] RatioQ = FractionBits'(25035);
  localparam logic [ProdWidth-1:0]    RoundHalf = ProdWidth'(1) << (FractionBits - 1);

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_LOSS  = 1'b1
  } mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_RANGE_LOW     = 8'd0,
    REG_RANGE_HIGH    = 8'd1,
    REG_STOP_WIDTH    = 8'd2,
    REG_ITERATION_CAP = 8'd3
  } reg_idx_e;

  localparam value_t RangeLowReset     = ValueWidth'(0);
  localparam value_t RangeHighReset    = ValueWidth'(65536);
  localparam value_t StopWidthReset    = ValueWidth'(66);
  localparam count_t IterationCapReset = CountWidth'(32);

  typedef struct packed {
    value_t range_low;
    value_t range_high;
    value_t stop_width;
    count_t iteration_cap;
  } cfg_t;

  typedef struct packed {
    logic   mode;
    value_t loss_first;
    value_t loss_second;
  } item_t;

  typedef struct packed {
    value_t probe_first;
    value_t probe_second;
    logic   finished;
    value_t estimate;
    logic   fault;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gss_if.sv =====
// ----------------------------------------------------------------------------
// gss interfaces
// Request, result and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gss_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] loss_first;
  logic [31:0] loss_second;

  modport source (output valid, mode, loss_first, loss_second, input ready);
  modport sink   (input valid, mode, loss_first, loss_second, output ready);
endinterface

interface gss_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] probe_first;
  logic [31:0] probe_second;
  logic        finished;
  logic [31:0] estimate;
  logic        fault;

  modport source (output valid, probe_first, probe_second, finished, estimate, fault,
                  input ready);
  modport sink   (input valid, probe_first, probe_second, finished, estimate, fault,
                  output ready);
endinterface

interface gss_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gss_cfg_regs
// Configuration register file: bounds, stop width and iteration cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             we_i,
  input  wire logic [gss_pkg::CfgIndexWidth-1:0] idx_i,
  input  wire logic [gss_pkg::ValueWidth-1:0]   data_i,
  output gss_pkg::cfg_t                         cfg_o
);
  import gss_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low     <= RangeLowReset;
      cfg_q.range_high    <= RangeHighReset;
      cfg_q.stop_width    <= StopWidthReset;
      cfg_q.iteration_cap <= IterationCapReset;
    end else if (we_i) begin
      unique case (idx_i)
        REG_RANGE_LOW:     cfg_q.range_low     <= data_i;
        REG_RANGE_HIGH:    cfg_q.range_high    <= data_i;
        REG_STOP_WIDTH:    cfg_q.stop_width    <= data_i;
        REG_ITERATION_CAP: cfg_q.iteration_cap <= data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gss_core.sv =====
// ----------------------------------------------------------------------------
// gss_core
// Search state and single-pass next-state / result logic for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire gss_pkg::item_t item_i,
  input  wire gss_pkg::cfg_t  cfg_i,
  output gss_pkg::result_t    result_o
);
  import gss_pkg::*;

  value_t low_q, low_d, high_q, high_d;
  value_t pa_q, pa_d, pb_q, pb_d;
  count_t cnt_q, cnt_d;
  logic   searching_q, searching_d;

  logic                 is_start, is_fault, first_lt;
  value_t               lo_n, hi_n, span_w, off, calc_a, calc_b, mid;
  logic [ProdWidth-1:0] prod;
  logic                 stop;

  always_comb begin
    is_start = (item_i.mode == MODE_START);
    is_fault = !is_start && !searching_q;
    first_lt = item_i.loss_first < item_i.loss_second;

    // interval after this request
    if (is_start) begin
      lo_n = cfg_i.range_low;
      hi_n = cfg_i.range_high;
    end else if (first_lt) begin
      lo_n = low_q;
      hi_n = pb_q;
    end else begin
      lo_n = pa_q;
      hi_n = high_q;
    end

    span_w = (hi_n >= lo_n) ? (hi_n - lo_n) : '0;
    prod   = ProdWidth'(span_w) * ProdWidth'(RatioQ) + RoundHalf;
    off    = prod[ProdWidth-1:FractionBits];
    calc_a = lo_n + off;
    calc_b = hi_n - off;

    cnt_d = is_start ? '0 : cnt_q + CountWidth'(1);
    stop  = (cnt_d >= cfg_i.iteration_cap) || (hi_n < lo_n) ||
            (span_w < cfg_i.stop_width);

    // floor((lo + hi) / 2) without a carry out
    mid = {1'b0, lo_n[ValueWidth-1:1]} + {1'b0, hi_n[ValueWidth-1:1]} +
          ValueWidth'(lo_n[0] & hi_n[0]);

    low_d  = lo_n;
    high_d = hi_n;
    if (is_start) begin
      pa_d = calc_a;
      pb_d = calc_b;
    end else if (first_lt) begin
      pa_d = calc_a;
      pb_d = pa_q;
    end else begin
      pa_d = pb_q;
      pb_d = calc_b;
    end
    searching_d = !stop;

    result_o = '0;
    if (is_fault) begin
      result_o.fault = 1'b1;
    end else if (stop) begin
      result_o.finished = 1'b1;
      result_o.estimate = mid;
    end else begin
      result_o.probe_first  = pa_d;
      result_o.probe_second = pb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      cnt_q       <= '0;
      searching_q <= 1'b0;
    end else if (accept_i && !is_fault) begin
      low_q       <= low_d;
      high_q      <= high_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      cnt_q       <= cnt_d;
      searching_q <= searching_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gss_out_buf.sv =====
// ----------------------------------------------------------------------------
// gss_out_buf
// Two-entry result buffer; keeps requests flowing while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire gss_pkg::result_t data_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output gss_pkg::result_t      data_o
);
  import gss_pkg::*;

  result_t    ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/golden_section_search_controller_core.sv =====
// ----------------------------------------------------------------------------
// golden_section_search_controller_core
// Golden-section search controller, unsigned Q16.16 interval and probes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i : register writes (index 0 range_low, 1 range_high, 2 stop_width,
//           3 iteration_cap); always ready, write only while idle.
//   in_i  : requests. mode 0 loads the bounds and starts a search, mode 1
//           carries the two losses measured at the last probe pair.
//   out_o : one result per request: next probe pair, or finished with the
//           midpoint estimate, or fault for a loss with no active search.
// Latency: offered the cycle after acceptance when no older result waits.
// Throughput: one request per cycle while the result buffer has space; the
//   whole update (span, one 32x16 constant multiply, probe add/sub, stop
//   compare) is combinational; search state is written at the accepting edge.
// Stall: a two-entry result buffer holds results while out_o is stalled;
//   in_i.ready drops only when both entries are occupied.
// Reset: config returns to its defaults, no search is active, the result
//   buffer is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module golden_section_search_controller_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gss_cfg_if.sink    cfg_i,
  gss_req_if.sink    in_i,
  gss_rsp_if.source  out_o
);
  import gss_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res, res_out;
  logic    accept, space, pop;

  assign cfg_i.ready = 1'b1;

  gss_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  assign item.mode        = in_i.mode;
  assign item.loss_first  = in_i.loss_first;
  assign item.loss_second = in_i.loss_second;
  assign in_i.ready       = space;
  assign accept           = in_i.valid && space;

  gss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign pop = out_o.valid && out_o.ready;

  gss_out_buf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign out_o.probe_first  = res_out.probe_first;
  assign out_o.probe_second = res_out.probe_second;
  assign out_o.finished     = res_out.finished;
  assign out_o.estimate     = res_out.estimate;
  assign out_o.fault        = res_out.fault;

endmodule

`default_nettype wire

// ===== hw/rtl/gss_checker.sv =====
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks on the search controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] probe_first_i,
  input wire logic [31:0] probe_second_i,
  input wire logic        finished_i,
  input wire logic [31:0] estimate_i,
  input wire logic        fault_i
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // results appear only after an accepted request
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without request");

  // a fault or finished result carries no probe pair; a fault carries no estimate
  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fault_i |-> !finished_i && probe_first_i == '0 &&
                               probe_second_i == '0 && estimate_i == '0)
    else $error("fault result carries data");

  a_finish_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finished_i |-> probe_first_i == '0 && probe_second_i == '0)
    else $error("finished result carries probes");

endmodule

bind golden_section_search_controller_core gss_checker u_gss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .probe_first_i  (out_o.probe_first),
  .probe_second_i (out_o.probe_second),
  .finished_i     (out_o.finished),
  .estimate_i     (out_o.estimate),
  .fault_i        (out_o.fault)
);

`default_nettype wire

// ===== bench/gss_search_checker.sv =====
// ----------------------------------------------------------------------------
// gss_search_checker
// Watches the config, request and result channels of the golden-section
// search core, tracks the search in its own model and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_search_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gss_cfg_if   cfg_mon,
  gss_req_if   req_mon,
  gss_rsp_if   rsp_mon,
  output int   mismatches_o,
  output int   pending_o
);
  import gss_pkg::*;

  // shadow of the core's registers and search state
  cfg_t    setup;
  value_t  win_low;
  value_t  win_high;
  value_t  pt_first;
  value_t  pt_second;
  count_t  evals;
  logic    active;
  int      mismatch_count;

  result_t predicted_results[$];

  // offset = round(width * 0.382), split so the product never overflows
  function automatic value_t golden_offset(value_t w);
    logic [63:0] upper;
    logic [63:0] lower;
    upper = 64'(w[ValueWidth-1:FractionBits]) * 64'(RatioQ);
    lower = 64'(w[FractionBits-1:0]) * 64'(RatioQ);
    return value_t'(upper + ((lower + 64'(RoundHalf)) >> FractionBits));
  endfunction

  // reversed bounds count as an empty interval
  function automatic value_t window_span();
    return (win_high >= win_low) ? win_high - win_low : '0;
  endfunction

  function automatic value_t window_middle(value_t a, value_t b);
    return (a >> 1) + (b >> 1) + value_t'(a[0] & b[0]);
  endfunction

  function automatic result_t next_search_result(item_t req);
    result_t r;
    value_t  off;
    r = '0;
    if (req.mode == MODE_START) begin
      win_low   = setup.range_low;
      win_high  = setup.range_high;
      off       = golden_offset(window_span());
      pt_first  = win_low + off;
      pt_second = win_high - off;
      evals     = '0;
    end else if (!active) begin
      r.fault = 1'b1;
      return r;
    end else if (req.loss_first < req.loss_second) begin
      win_high  = pt_second;
      pt_second = pt_first;
      pt_first  = win_low + golden_offset(window_span());
      evals     = evals + 1'b1;
    end else begin
      // equal losses land here: lower bound rises
      win_low   = pt_first;
      pt_first  = pt_second;
      pt_second = win_high - golden_offset(window_span());
      evals     = evals + 1'b1;
    end
    // stop_width and iteration_cap are read live
    if (evals >= setup.iteration_cap || win_high < win_low ||
        window_span() < setup.stop_width) begin
      active     = 1'b0;
      r.finished = 1'b1;
      r.estimate = window_middle(win_low, win_high);
    end else begin
      active         = 1'b1;
      r.probe_first  = pt_first;
      r.probe_second = pt_second;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, predicted %h", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t   req;
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      setup     = '{RangeLowReset, RangeHighReset, StopWidthReset, IterationCapReset};
      win_low   = '0;
      win_high  = '0;
      pt_first  = '0;
      pt_second = '0;
      evals     = '0;
      active    = 1'b0;
      mismatch_count = 0;
      predicted_results.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // a result can never belong to the request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.probe_first  = rsp_mon.probe_first;
        seen.probe_second = rsp_mon.probe_second;
        seen.finished     = rsp_mon.finished;
        seen.estimate     = rsp_mon.estimate;
        seen.fault        = rsp_mon.fault;
        if (predicted_results.size() == 0) begin
          report_mismatch("unrequested result", seen.estimate, '0);
        end else begin
          want = predicted_results.pop_front();
          if (seen.probe_first !== want.probe_first)
            report_mismatch("probe_first", seen.probe_first, want.probe_first);
          if (seen.probe_second !== want.probe_second)
            report_mismatch("probe_second", seen.probe_second, want.probe_second);
          if (seen.finished !== want.finished)
            report_mismatch("finished", 32'(seen.finished), 32'(want.finished));
          if (seen.estimate !== want.estimate)
            report_mismatch("estimate", seen.estimate, want.estimate);
          if (seen.fault !== want.fault)
            report_mismatch("fault", 32'(seen.fault), 32'(want.fault));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_RANGE_LOW:     setup.range_low     = cfg_mon.data;
          REG_RANGE_HIGH:    setup.range_high    = cfg_mon.data;
          REG_STOP_WIDTH:    setup.stop_width    = cfg_mon.data;
          REG_ITERATION_CAP: setup.iteration_cap = cfg_mon.data[CountWidth-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        req.mode        = req_mon.mode;
        req.loss_first  = req_mon.loss_first;
        req.loss_second = req_mon.loss_second;
        predicted_results.push_back(next_search_result(req));
      end
      mismatches_o <= mismatch_count;
      pending_o    <= predicted_results.size();
    end
  end

endmodule

// ===== bench/tb_golden_section_search_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_golden_section_search_controller_core
// Directed corner cases, then random search sequences under random config,
// with random gaps on requests and random stalls on results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_golden_section_search_controller_core;
  import gss_pkg::*;

  localparam int ItemTarget    = 1950;
  localparam int WatchdogLimit = 2000;
  localparam logic [CfgIndexWidth-1:0] RegUnused = 8'hA5;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet_bus = 1'b0;
  int   sent_count = 0;
  int   quiet_cycles = 0;
  int   mismatch_count;
  int   pending_count;

  gss_cfg_if cfg_ch ();
  gss_req_if req_ch ();
  gss_rsp_if rsp_ch ();

  golden_section_search_controller_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  gss_search_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_mon      (cfg_ch),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .mismatches_o (mismatch_count),
    .pending_o    (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ends the run when no channel has moved for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL golden_section_search_controller_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each result, none in quiet phases
  initial begin : result_side
    int stall;
    rsp_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet_bus ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic send_req(mode_e m, value_t first, value_t second);
    int gap;
    gap = quiet_bus ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.loss_first  <= first;
    req_ch.loss_second <= second;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sent_count++;
  endtask

  function automatic value_t draw_loss();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_loss();
    value_t a;
    value_t b;
    a = draw_loss();
    b = ($urandom_range(0, 7) == 0) ? a : draw_loss();
    send_req(MODE_LOSS, a, b);
  endtask

  // lets every outstanding request finish before config changes
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [31:0] data, bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_setup(cfg_t s);
    logic [31:0] cap_word;
    cap_word = $urandom;          // upper bits must be dropped by the core
    cap_word[CountWidth-1:0] = s.iteration_cap;
    write_reg(REG_RANGE_LOW, s.range_low, 1'b0);
    write_reg(REG_RANGE_HIGH, s.range_high, 1'b0);
    write_reg(REG_STOP_WIDTH, s.stop_width, 1'b0);
    write_reg(REG_ITERATION_CAP, cap_word, 1'b1);
  endtask

  function automatic cfg_t draw_setup();
    cfg_t s;
    case ($urandom_range(0, 9))
      0: begin
        s.range_low  = $urandom;
        s.range_high = $urandom;
      end
      1: begin
        s.range_low  = '0;
        s.range_high = '1;
      end
      2: begin
        s.range_low  = $urandom;
        s.range_high = s.range_low;
      end
      default: begin
        s.range_low  = $urandom_range(0, 32'h00FF_FFFF);
        s.range_high = s.range_low + $urandom_range(1, 32'h0040_0000);
      end
    endcase
    case ($urandom_range(0, 7))
      0:       s.stop_width = '0;
      1:       s.stop_width = '1;
      2:       s.stop_width = $urandom;
      default: s.stop_width = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(0, 7))
      0:       s.iteration_cap = '0;
      1:       s.iteration_cap = '1;
      default: s.iteration_cap = $urandom_range(1, 40);
    endcase
    return s;
  endfunction

  initial begin : stimulus
    cfg_t setup;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= MODE_START;
    req_ch.loss_first  <= '0;
    req_ch.loss_second <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    setup = '{RangeLowReset, RangeHighReset, StopWidthReset, IterationCapReset};
    send_req(MODE_LOSS, '0, '1);          // no search yet: fault
    send_req(MODE_START, '1, '0);
    send_req(MODE_LOSS, '0, '1);
    send_req(MODE_LOSS, '1, '0);
    send_req(MODE_LOSS, 32'd5, 32'd5);    // tie: lower bound rises
    send_req(MODE_LOSS, '1, '1);
    send_req(MODE_START, '0, '0);         // restart mid-search
    send_req(MODE_LOSS, 32'd1, 32'd2);
    drain_results();
    write_reg(REG_STOP_WIDTH, '1, 1'b1);  // live threshold change ends the search
    send_req(MODE_LOSS, 32'd2, 32'd1);
    send_req(MODE_LOSS, 32'd2, 32'd1);
    drain_results();
    setup.iteration_cap = '0;
    program_setup(setup);
    send_req(MODE_START, '0, '0);         // cap 0: done at start
    drain_results();
    setup.range_low     = '1;
    setup.range_high    = '0;
    setup.iteration_cap = '1;
    program_setup(setup);
    send_req(MODE_START, '1, '1);         // reversed bounds
    drain_results();
    setup.range_low  = '0;
    setup.range_high = '1;
    setup.stop_width = '0;
    program_setup(setup);
    send_req(MODE_START, '0, '0);
    send_req(MODE_LOSS, '0, '1);
    send_req(MODE_LOSS, '1, '0);
    send_req(MODE_LOSS, '1, '1);
    send_req(MODE_LOSS, 32'h8000_0000, 32'h7FFF_FFFF);
    drain_results();
    write_reg(REG_ITERATION_CAP, 32'd2, 1'b1);  // live cap below count
    send_req(MODE_LOSS, 32'd7, 32'd9);
    drain_results();
    setup.range_low     = 32'd100;
    setup.range_high    = 32'd100;
    setup.stop_width    = 32'd1;
    setup.iteration_cap = IterationCapReset;
    program_setup(setup);
    send_req(MODE_START, '0, '0);         // too narrow at start
    drain_results();
    write_reg(RegUnused, '1, 1'b1);
    setup = '{RangeLowReset, RangeHighReset, StopWidthReset, IterationCapReset};
    program_setup(setup);
    send_req(MODE_START, '0, '0);
    send_req(MODE_LOSS, 32'd3, 32'd4);

    // ---- random part: mostly complete searches, some noise ----
    while (sent_count < ItemTarget) begin
      drain_results();
      program_setup(draw_setup());
      quiet_bus = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) send_random_loss();
        send_req(MODE_START, $urandom, $urandom);
        repeat ($urandom_range(1, 45)) begin
          if ($urandom_range(0, 29) == 0) send_req(MODE_START, $urandom, $urandom);
          else send_random_loss();
        end
        if ($urandom_range(0, 5) == 0) begin
          drain_results();
          if ($urandom_range(0, 1) == 0)
            write_reg(REG_STOP_WIDTH, $urandom_range(0, 8192), 1'b1);
          else
            write_reg(REG_ITERATION_CAP, $urandom_range(0, 48), 1'b1);
          repeat ($urandom_range(1, 10)) send_random_loss();
        end
      end
    end
    quiet_bus = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS golden_section_search_controller_core");
    end else begin
      $display("FAIL golden_section_search_controller_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gss_pkg.sv
hw/rtl/gss_if.sv
hw/rtl/gss_cfg_regs.sv
hw/rtl/gss_core.sv
hw/rtl/gss_out_buf.sv
hw/rtl/golden_section_search_controller_core.sv
hw/rtl/gss_checker.sv
bench/gss_search_checker.sv
bench/tb_golden_section_search_controller_core.sv
